FILE: rtl/lcdts_pkg.sv
// Shared types and constants for the character LCD tick sequencer.
// No dependencies; imported by lcdts_ctrl, lcdts_out_buf and the top level.
package lcdts_pkg;

	// Build-time choices of the display hookup
	localparam bit FOUR_BIT_BUS       = 1'b1;
	localparam int BUF_DEPTH_DEFAULT  = 32;
	localparam int INIT_WAIT_TICKS    = 20;
	localparam int TICK_PERIOD_MS     = 2;
	localparam int COLUMNS            = 16;
	localparam int ROWS               = 2;

	localparam int WAIT_W  = 5;
	localparam int FRZ_W   = 16;
	localparam int CFG_IDX_W = 2;

	// Request codes
	localparam logic [2:0] ACT_TICK   = 3'd0;
	localparam logic [2:0] ACT_LOAD   = 3'd1;
	localparam logic [2:0] ACT_MOVE   = 3'd2;
	localparam logic [2:0] ACT_CLEAR  = 3'd3;
	localparam logic [2:0] ACT_FREEZE = 3'd4;

	// Status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BUSY    = 2'd1;
	localparam logic [1:0] ST_BAD_POS = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TWO_LINES  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LARGE_FONT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_ON  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_ON   = 2'd3;

	// LCD command bytes
	localparam logic [7:0] FS_BASE_4BIT = 8'h20;
	localparam logic [7:0] FS_BASE_8BIT = 8'h30;
	localparam logic [7:0] CMD_DISP_CTL = 8'h0C;
	localparam logic [7:0] CMD_CLEAR    = 8'h01;
	localparam logic [7:0] CMD_DDRAM    = 8'h80;
	localparam logic [7:0] ROW1_OFFSET  = 8'h40;

	typedef struct packed {
		logic [1:0] status;
		logic       rs;
		logic       en;
		logic [7:0] bus;
		logic       done;
		logic       idle;
	} result_t;

endpackage

FILE: rtl/lcdts_char_mem.sv
// Character buffer: one write port, one registered read port.
// Depends on nothing; a write to the address being read is forwarded.
module lcdts_char_mem #(
	parameter int DEPTH  = 32,
	parameter int ADDR_W = 5
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [7:0]        rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Write-first: a same-cycle write to the read address wins
	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/lcdts_ctrl.sv
// Job sequencer of the LCD controller: init, write, command and freeze jobs.
// Depends on lcdts_pkg; reads characters through lcdts_char_mem.
module lcdts_ctrl import lcdts_pkg::*; #(
	parameter int BUFFER_DEPTH = BUF_DEPTH_DEFAULT,
	parameter int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1,
	parameter int CNT_W  = $clog2(BUFFER_DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic [2:0]           action,
	input  logic [7:0]           char_code,
	input  logic                 last_char,
	input  logic [5:0]           column,
	input  logic [1:0]           row,
	input  logic [FRZ_W-1:0]     freeze_ms,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic                 cfg_bit,
	output logic                 mem_we,
	output logic [ADDR_W-1:0]    mem_waddr,
	output logic [7:0]           mem_wdata,
	output logic [ADDR_W-1:0]    mem_raddr,
	input  logic [7:0]           mem_rdata,
	output result_t              res
);

	typedef enum logic [2:0] {
		MODE_INIT,
		MODE_IDLE,
		MODE_FREEZE,
		MODE_WRITE,
		MODE_CLEAR,
		MODE_MOVE
	} mode_t;

	typedef struct packed {
		logic       rs;
		logic       en;
		logic [7:0] bus;
	} pins_t;

	typedef struct packed {
		pins_t      pins;
		logic [1:0] phase;
		logic       fin;
	} strobe_t;

	// Freeze length: divide by the tick period through a reciprocal multiply
	localparam int DIV_SH = FRZ_W + $clog2(TICK_PERIOD_MS);
	localparam int PROD_W = FRZ_W + DIV_SH;
	localparam logic [FRZ_W:0] DIV_M = (FRZ_W + 1)'(
		((64'd1 << DIV_SH) + 64'(TICK_PERIOD_MS) - 64'd1) / 64'(TICK_PERIOD_MS));

	mode_t               mode_q, mode_d;
	logic [WAIT_W-1:0]   wait_q, wait_d;
	logic [1:0]          cmd_q, cmd_d;
	logic [1:0]          phase_q, phase_d;
	logic                extra_q, extra_d;
	logic [CNT_W-1:0]    fill_q, fill_d;
	logic [CNT_W-1:0]    send_q, send_d;
	logic [7:0]          pend_q, pend_d;
	logic [FRZ_W-1:0]    tgt_q, tgt_d;
	logic [FRZ_W-1:0]    cnt_q, cnt_d;
	pins_t               pins_q, pins_d;
	logic                two_lines_q, large_font_q, cursor_on_q, blink_on_q;

	logic [7:0]          init_b;
	logic [PROD_W-1:0]   prod;
	logic [FRZ_W-1:0]    quot;
	logic [FRZ_W-1:0]    frz_len;
	logic [1:0]          status;
	logic                done;
	strobe_t             st;

	function automatic strobe_t strobe(input logic [7:0] data_b, input logic rs_b,
		input logic [1:0] phase, input pins_t cur);
		strobe_t s;
		s.pins  = cur;
		s.phase = phase;
		s.fin   = 1'b0;
		if (FOUR_BIT_BUS) begin
			case (phase)
				2'd0: begin
					s.pins  = '{rs: rs_b, en: 1'b1, bus: {4'h0, data_b[7:4]}};
					s.phase = 2'd1;
				end
				2'd1: begin
					s.pins.en = 1'b0;
					s.phase   = 2'd2;
				end
				2'd2: begin
					s.pins  = '{rs: rs_b, en: 1'b1, bus: {4'h0, data_b[3:0]}};
					s.phase = 2'd3;
				end
				default: begin
					s.pins.en = 1'b0;
					s.phase   = 2'd0;
					s.fin     = 1'b1;
				end
			endcase
		end else if (phase == 2'd0) begin
			s.pins  = '{rs: rs_b, en: 1'b1, bus: data_b};
			s.phase = 2'd1;
		end else begin
			s.pins.en = 1'b0;
			s.phase   = 2'd0;
			s.fin     = 1'b1;
		end
		return s;
	endfunction

	always_comb begin
		case (cmd_q)
			2'd0: init_b = (FOUR_BIT_BUS ? FS_BASE_4BIT : FS_BASE_8BIT)
				| {4'h0, two_lines_q, large_font_q, 2'b00};
			2'd1: init_b = CMD_DISP_CTL | {6'h00, cursor_on_q, blink_on_q};
			default: init_b = CMD_CLEAR;
		endcase
	end

	assign prod    = PROD_W'(freeze_ms) * PROD_W'(DIV_M);
	assign quot    = prod[PROD_W-1 -: FRZ_W];
	assign frz_len = (quot == '1) ? quot : quot + FRZ_W'(1);

	always_comb begin
		mode_d  = mode_q;
		wait_d  = wait_q;
		cmd_d   = cmd_q;
		phase_d = phase_q;
		extra_d = extra_q;
		fill_d  = fill_q;
		send_d  = send_q;
		pend_d  = pend_q;
		tgt_d   = tgt_q;
		cnt_d   = cnt_q;
		pins_d  = pins_q;
		status  = ST_OK;
		done    = 1'b0;
		mem_we  = 1'b0;
		st      = '0;
		if (fire) begin
			if (action == ACT_TICK) begin
				case (mode_q)
					MODE_INIT: begin
						if (wait_q < WAIT_W'(INIT_WAIT_TICKS)) begin
							wait_d = wait_q + WAIT_W'(1);
						end else if (FOUR_BIT_BUS && !extra_q && cmd_q == 2'd0) begin
							// lone high-nibble pulse ahead of function set
							if (phase_q == 2'd0) begin
								pins_d  = '{rs: 1'b0, en: 1'b1, bus: {4'h0, init_b[7:4]}};
								phase_d = 2'd1;
							end else begin
								pins_d.en = 1'b0;
								phase_d   = 2'd0;
								extra_d   = 1'b1;
							end
						end else begin
							st      = strobe(init_b, 1'b0, phase_q, pins_q);
							pins_d  = st.pins;
							phase_d = st.phase;
							if (st.fin) begin
								if (cmd_q == 2'd2) begin
									cmd_d   = 2'd0;
									extra_d = 1'b0;
									mode_d  = MODE_IDLE;
									done    = 1'b1;
								end else begin
									cmd_d = cmd_q + 2'd1;
								end
							end
						end
					end
					MODE_FREEZE: begin
						if (cnt_q < tgt_q) begin
							cnt_d = cnt_q + FRZ_W'(1);
						end else begin
							cnt_d  = '0;
							tgt_d  = '0;
							mode_d = MODE_IDLE;
							done   = 1'b1;
						end
					end
					MODE_WRITE: begin
						st      = strobe(mem_rdata, 1'b1, phase_q, pins_q);
						pins_d  = st.pins;
						phase_d = st.phase;
						if (st.fin) begin
							if (({1'b0, send_q} + (CNT_W + 1)'(1)) >= {1'b0, fill_q}) begin
								send_d = '0;
								fill_d = '0;
								mode_d = MODE_IDLE;
								done   = 1'b1;
							end else begin
								send_d = send_q + CNT_W'(1);
							end
						end
					end
					MODE_CLEAR, MODE_MOVE: begin
						st      = strobe(pend_q, 1'b0, phase_q, pins_q);
						pins_d  = st.pins;
						phase_d = st.phase;
						if (st.fin) begin
							mode_d = MODE_IDLE;
							done   = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end else if (action inside {[ACT_LOAD:ACT_FREEZE]}) begin
				if (mode_q != MODE_IDLE) begin
					status = ST_BUSY;
				end else begin
					case (action)
						ACT_LOAD: begin
							// drop characters beyond the buffer, still honor last
							if (fill_q < CNT_W'(BUFFER_DEPTH)) begin
								mem_we = 1'b1;
								fill_d = fill_q + CNT_W'(1);
							end
							if (last_char && fill_d != '0) begin
								send_d  = '0;
								phase_d = 2'd0;
								mode_d  = MODE_WRITE;
							end
						end
						ACT_MOVE: begin
							if (column >= 6'(COLUMNS) || row >= 2'(ROWS)) begin
								status = ST_BAD_POS;
							end else begin
								pend_d  = CMD_DDRAM | ((row != 2'd0) ? ROW1_OFFSET : 8'h00)
									| {2'b00, column};
								phase_d = 2'd0;
								mode_d  = MODE_MOVE;
							end
						end
						ACT_CLEAR: begin
							pend_d  = CMD_CLEAR;
							phase_d = 2'd0;
							mode_d  = MODE_CLEAR;
						end
						default: begin
							tgt_d  = frz_len;
							cnt_d  = '0;
							mode_d = MODE_FREEZE;
						end
					endcase
				end
			end
		end
	end

	assign mem_waddr = fill_q[ADDR_W-1:0];
	assign mem_wdata = char_code;
	// read ahead at the index the next tick will send
	assign mem_raddr = send_d[ADDR_W-1:0];

	assign res = '{status: status, rs: pins_d.rs, en: pins_d.en, bus: pins_d.bus,
		done: done, idle: (mode_d == MODE_IDLE)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_INIT;
			wait_q       <= '0;
			cmd_q        <= '0;
			phase_q      <= '0;
			extra_q      <= 1'b0;
			fill_q       <= '0;
			send_q       <= '0;
			pend_q       <= '0;
			tgt_q        <= '0;
			cnt_q        <= '0;
			pins_q       <= '0;
			two_lines_q  <= 1'b1;
			large_font_q <= 1'b0;
			cursor_on_q  <= 1'b0;
			blink_on_q   <= 1'b0;
		end else begin
			mode_q  <= mode_d;
			wait_q  <= wait_d;
			cmd_q   <= cmd_d;
			phase_q <= phase_d;
			extra_q <= extra_d;
			fill_q  <= fill_d;
			send_q  <= send_d;
			pend_q  <= pend_d;
			tgt_q   <= tgt_d;
			cnt_q   <= cnt_d;
			pins_q  <= pins_d;
			if (cfg_we) begin
				case (cfg_idx)
					CFG_TWO_LINES:  two_lines_q  <= cfg_bit;
					CFG_LARGE_FONT: large_font_q <= cfg_bit;
					CFG_CURSOR_ON:  cursor_on_q  <= cfg_bit;
					CFG_BLINK_ON:   blink_on_q   <= cfg_bit;
					default: begin
					end
				endcase
			end
		end
	end

endmodule

FILE: rtl/lcdts_out_buf.sv
// Result register with a skid stage for the output channel.
// Depends on lcdts_pkg for the result beat type.
module lcdts_out_buf import lcdts_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    full,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_data
);

	logic    out_valid_q, skid_valid_q;
	result_t out_q, skid_q;
	logic    pop;

	assign pop = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_q <= push_data;
			end else begin
				out_q <= push_data;
			end
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: rtl/char_lcd_tick_sequencer.sv
// Top level of the tick-driven character LCD controller.
// Depends on lcdts_pkg, lcdts_char_mem, lcdts_ctrl and lcdts_out_buf.
//
// Usage:
//   Input channel (in_valid / in_stall): one beat is a tick or a request
//   (load character, move cursor, clear, freeze). Every accepted beat gives
//   exactly one result beat on the output channel (out_valid / out_stall)
//   carrying status, the LCD pin levels (RS, E, data bus), the job-done pulse
//   and the idle flag, all as they stand after that beat.
//   Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) sets the
//   function-set and display-control bits; cfg_ready is always high. Write
//   it only while no job runs, since the init and command bytes read it live.
//   Output: each result is registered in the result register or skid entry.
//   Throughput: one beat per cycle while in_stall is low; the per-beat state
//   update and the registered read of the character buffer (read ahead at
//   the next index) both keep up with that rate.
//   Stall: a result register plus one skid entry hold results; in_stall rises
//   only when both are occupied and drops as soon as the output drains.
//   Reset: the controller starts its power-on init job (wait, then function
//   set, display control, clear); pins go low, config takes its reset values.
//   The character buffer is not cleared and needs no clearing pass.
module char_lcd_tick_sequencer import lcdts_pkg::*; #(
	parameter int BUFFER_DEPTH = BUF_DEPTH_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [2:0]           action,
	input  logic [7:0]           char_code,
	input  logic                 last_char,
	input  logic [5:0]           column,
	input  logic [1:0]           row,
	input  logic [FRZ_W-1:0]     freeze_ms,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           status,
	output logic                 register_select,
	output logic                 enable_pin,
	output logic [7:0]           bus_value,
	output logic                 job_done,
	output logic                 idle,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic                 cfg_data
);

	localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);

	logic              fire;
	logic              buf_full;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [7:0]        mem_wdata, mem_rdata;
	result_t           step_res, out_res;

	// Take a beat whenever the skid entry is free
	assign in_stall  = buf_full;
	assign fire      = in_valid && !buf_full;
	assign cfg_ready = 1'b1;

	lcdts_char_mem #(
		.DEPTH  (BUFFER_DEPTH),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	lcdts_ctrl #(
		.BUFFER_DEPTH (BUFFER_DEPTH),
		.ADDR_W       (ADDR_W),
		.CNT_W        (CNT_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.action    (action),
		.char_code (char_code),
		.last_char (last_char),
		.column    (column),
		.row       (row),
		.freeze_ms (freeze_ms),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_idx   (cfg_index),
		.cfg_bit   (cfg_data),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.res       (step_res)
	);

	lcdts_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire),
		.push_data (step_res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_res)
	);

	assign status          = out_res.status;
	assign register_select = out_res.rs;
	assign enable_pin      = out_res.en;
	assign bus_value       = out_res.bus;
	assign job_done        = out_res.done;
	assign idle            = out_res.idle;

endmodule
